>>> hdl/lsc_pkg.sv
// Package: types, widths, region codes and helpers for the line segment clipper.
package lsc_pkg;

    localparam int COORD_BITS = 16;
    // Working coordinates are wider: a moved endpoint may leave the input range.
    localparam int WIDE_BITS  = 36;
    localparam int DIFF_BITS  = WIDE_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int MAX_ROUNDS = 4;
    localparam int ROUND_BITS = $clog2(MAX_ROUNDS + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WIDE_BITS-1:0]  t_wide;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic [1:0]                   t_cfg_idx;
    typedef logic [3:0]                   t_code;

    localparam t_cfg_idx REG_LEFT   = 2'd0;
    localparam t_cfg_idx REG_RIGHT  = 2'd1;
    localparam t_cfg_idx REG_BOTTOM = 2'd2;
    localparam t_cfg_idx REG_TOP    = 2'd3;

    localparam t_code CODE_LEFT   = 4'd1;
    localparam t_code CODE_RIGHT  = 4'd2;
    localparam t_code CODE_BOTTOM = 4'd4;
    localparam t_code CODE_TOP    = 4'd8;

    localparam t_coord RESET_LEFT   = 16'sd100;
    localparam t_coord RESET_RIGHT  = 16'sd300;
    localparam t_coord RESET_BOTTOM = 16'sd100;
    localparam t_coord RESET_TOP    = 16'sd300;

    // Outcode of a point against the window.
    function automatic t_code region(t_wide x, t_wide y, t_wide l, t_wide r,
                                     t_wide b, t_wide t);
        t_code c;
        c = '0;
        if (x < l) begin
            c = c | CODE_LEFT;
        end else if (x > r) begin
            c = c | CODE_RIGHT;
        end
        if (y < b) begin
            c = c | CODE_BOTTOM;
        end else if (y > t) begin
            c = c | CODE_TOP;
        end
        return c;
    endfunction

    function automatic logic [DIFF_BITS-1:0] mag(t_diff v);
        return v[DIFF_BITS-1] ? DIFF_BITS'(-v) : DIFF_BITS'(v);
    endfunction

endpackage

>>> hdl/lsc_seg_if.sv
// Interface: segment input channel.
interface lsc_seg_if;
    logic valid;
    logic ready;
    lsc_pkg::t_coord start_x;
    lsc_pkg::t_coord start_y;
    lsc_pkg::t_coord end_x;
    lsc_pkg::t_coord end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> hdl/lsc_res_if.sv
// Interface: clip result output channel.
interface lsc_res_if;
    logic valid;
    logic ready;
    logic accepted;
    lsc_pkg::t_coord clip_start_x;
    lsc_pkg::t_coord clip_start_y;
    lsc_pkg::t_coord clip_end_x;
    lsc_pkg::t_coord clip_end_y;

    modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                    clip_end_y, input ready);
    modport sink   (input valid, accepted, clip_start_x, clip_start_y, clip_end_x,
                    clip_end_y, output ready);
endinterface

>>> hdl/lsc_muldiv.sv
// Module: sequential a*b/c with truncation toward zero (shift-add, then restoring divide).
module lsc_muldiv (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lsc_pkg::t_diff i_a,
    input  lsc_pkg::t_diff i_b,
    input  lsc_pkg::t_diff i_c,
    output logic           o_done,
    output lsc_pkg::t_diff o_q
);
    import lsc_pkg::*;

    localparam int CNT_BITS = $clog2(PROD_BITS);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} t_state;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [PROD_BITS-1:0]  r_acc;
    logic [PROD_BITS-1:0]  r_mcand;
    logic [DIFF_BITS-1:0]  r_mplier;
    logic [DIFF_BITS-1:0]  r_div;
    logic [DIFF_BITS-1:0]  r_rem;
    logic [DIFF_BITS-1:0]  r_q;
    logic                  r_neg;
    logic [DIFF_BITS:0]    n_rem;
    logic                  n_fit;

    assign n_rem = {r_rem, r_acc[PROD_BITS-1]};
    assign n_fit = n_rem >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mcand  <= PROD_BITS'(mag(i_a));
                        r_mplier <= mag(i_b);
                        r_div    <= mag(i_c);
                        r_neg    <= i_a[DIFF_BITS-1] ^ i_b[DIFF_BITS-1] ^ i_c[DIFF_BITS-1];
                        r_acc    <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == CNT_BITS'(DIFF_BITS - 1)) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DIV: begin
                    r_acc <= r_acc << 1;
                    if (n_fit) begin
                        r_rem <= DIFF_BITS'(n_rem - {1'b0, r_div});
                    end else begin
                        r_rem <= DIFF_BITS'(n_rem);
                    end
                    r_q   <= {r_q[DIFF_BITS-2:0], n_fit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_BITS'(PROD_BITS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == S_DONE);
    // A zero divisor yields zero.
    assign o_q = (r_div == '0) ? '0 : (r_neg ? -t_diff'(r_q) : t_diff'(r_q));

endmodule

>>> hdl/line_segment_window_clipper_unit.sv
// Top level: Cohen-Sutherland line clipper against a programmable window.
//
//  Channel   Dir  Handshake          Payload
//  i_seg     in   valid/ready        start_x, start_y, end_x, end_y (16-bit signed)
//  o_res     out  valid/ready        accepted, clip_start_x/y, clip_end_x/y
//  i_cfg_*   in   write enable only  index 0..3 (left, right, bottom, top), 16-bit data
//
// Each region test is made in the evaluate state. Each endpoint move then waits on the
// single serial multiply/divide unit: 37 multiply steps, 74 divide steps and a done
// state. A segment takes at most four moves. The block returns to idle after each
// segment to take the next one, so one segment is in work at a time.
// Reset is synchronous and active low; it loads the default window.
// The finished beat sits in an output register, so a stalled sink only holds
// the next segment at its final step.
module line_segment_window_clipper_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  lsc_pkg::t_cfg_idx i_cfg_idx,
    input  lsc_pkg::t_coord   i_cfg_data,
    lsc_seg_if.sink           i_seg,
    lsc_res_if.source         o_res
);
    import lsc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_WAIT} t_state;

    t_state                r_state;
    t_coord                r_win_l, r_win_r, r_win_b, r_win_t;
    t_wide                 r_x1, r_y1, r_x2, r_y2;
    logic [ROUND_BITS-1:0] r_round;
    logic                  r_move1;
    logic                  r_yedge;   // Moving onto a horizontal edge (top or bottom).
    t_wide                 r_edge;
    logic                  r_out_valid;
    logic                  r_out_acc;
    t_coord                r_out_x1, r_out_y1, r_out_x2, r_out_y2;

    t_wide  w_l, w_r, w_b, w_t;
    t_code  n_c1, n_c2, n_c;
    logic   n_start;
    t_diff  n_a, n_b, n_div;
    t_diff  n_q;
    logic   n_done;
    logic   n_accept, n_reject, n_finish, n_out_free;
    t_wide  n_edge;
    logic   n_yedge;
    t_wide  n_moved;

    assign w_l = WIDE_BITS'(r_win_l);
    assign w_r = WIDE_BITS'(r_win_r);
    assign w_b = WIDE_BITS'(r_win_b);
    assign w_t = WIDE_BITS'(r_win_t);

    assign n_c1 = region(r_x1, r_y1, w_l, w_r, w_b, w_t);
    assign n_c2 = region(r_x2, r_y2, w_l, w_r, w_b, w_t);
    assign n_c  = (n_c1 != '0) ? n_c1 : n_c2;

    assign n_accept   = ((n_c1 | n_c2) == '0);
    // Shared outcode bits, or the round budget spent, end the work as a reject.
    assign n_reject   = !n_accept && (((n_c1 & n_c2) != '0) ||
                        (r_round == ROUND_BITS'(MAX_ROUNDS)));
    assign n_out_free = !r_out_valid || o_res.ready;
    assign n_finish   = (r_state == S_EVAL) && (n_accept || n_reject) && n_out_free;
    assign n_start    = (r_state == S_EVAL) && !n_accept && !n_reject;

    // Edge priority: top, bottom, right, left.
    always_comb begin
        n_yedge = 1'b1;
        n_edge  = w_t;
        if ((n_c & CODE_TOP) != '0) begin
            n_yedge = 1'b1;
            n_edge  = w_t;
        end else if ((n_c & CODE_BOTTOM) != '0) begin
            n_yedge = 1'b1;
            n_edge  = w_b;
        end else if ((n_c & CODE_RIGHT) != '0) begin
            n_yedge = 1'b0;
            n_edge  = w_r;
        end else begin
            n_yedge = 1'b0;
            n_edge  = w_l;
        end
        if (n_yedge) begin
            n_a   = DIFF_BITS'(r_x2) - DIFF_BITS'(r_x1);
            n_b   = DIFF_BITS'(n_edge) - DIFF_BITS'(r_y1);
            n_div = DIFF_BITS'(r_y2) - DIFF_BITS'(r_y1);
        end else begin
            n_a   = DIFF_BITS'(r_y2) - DIFF_BITS'(r_y1);
            n_b   = DIFF_BITS'(n_edge) - DIFF_BITS'(r_x1);
            n_div = DIFF_BITS'(r_x2) - DIFF_BITS'(r_x1);
        end
    end

    lsc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_a     (n_a),
        .i_b     (n_b),
        .i_c     (n_div),
        .o_done  (n_done),
        .o_q     (n_q)
    );

    // The intersection is always measured from the first endpoint.
    assign n_moved = r_yedge ? WIDE_BITS'(DIFF_BITS'(r_x1) + n_q)
                             : WIDE_BITS'(DIFF_BITS'(r_y1) + n_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_win_l     <= RESET_LEFT;
            r_win_r     <= RESET_RIGHT;
            r_win_b     <= RESET_BOTTOM;
            r_win_t     <= RESET_TOP;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_LEFT:   r_win_l <= i_cfg_data;
                    REG_RIGHT:  r_win_r <= i_cfg_data;
                    REG_BOTTOM: r_win_b <= i_cfg_data;
                    REG_TOP:    r_win_t <= i_cfg_data;
                    default:    ;
                endcase
            end
            // A beat taken by the sink empties the register unless a new one replaces it.
            if (r_out_valid && o_res.ready && !n_finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_seg.valid) begin
                        r_x1    <= WIDE_BITS'(i_seg.start_x);
                        r_y1    <= WIDE_BITS'(i_seg.start_y);
                        r_x2    <= WIDE_BITS'(i_seg.end_x);
                        r_y2    <= WIDE_BITS'(i_seg.end_y);
                        r_round <= '0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (n_finish) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= n_accept;
                        r_out_x1    <= n_accept ? COORD_BITS'(r_x1) : '0;
                        r_out_y1    <= n_accept ? COORD_BITS'(r_y1) : '0;
                        r_out_x2    <= n_accept ? COORD_BITS'(r_x2) : '0;
                        r_out_y2    <= n_accept ? COORD_BITS'(r_y2) : '0;
                        r_state     <= S_IDLE;
                    end else if (n_start) begin
                        r_move1 <= (n_c1 != '0);
                        r_yedge <= n_yedge;
                        r_edge  <= n_edge;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (n_done) begin
                        if (r_move1) begin
                            r_x1 <= r_yedge ? n_moved : r_edge;
                            r_y1 <= r_yedge ? r_edge : n_moved;
                        end else begin
                            r_x2 <= r_yedge ? n_moved : r_edge;
                            r_y2 <= r_yedge ? r_edge : n_moved;
                        end
                        r_round <= r_round + 1'b1;
                        r_state <= S_EVAL;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_seg.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.accepted     = r_out_acc;
    assign o_res.clip_start_x = r_out_x1;
    assign o_res.clip_start_y = r_out_y1;
    assign o_res.clip_end_x   = r_out_x2;
    assign o_res.clip_end_y   = r_out_y2;

endmodule

>>> bench/tb_types.sv
`timescale 1ns / 1ps
// Bench types: one clip result beat and one directed stimulus row.
package tb_types;
    import lsc_pkg::*;

    typedef struct packed {
        logic   accepted;
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_clip_beat;

    typedef struct {
        t_coord     sx, sy, ex, ey;
        bit         typed;
        t_clip_beat want;
    } t_seg_row;
endpackage

>>> bench/tb.sv
`timescale 1ns / 1ps
// Bench top: drives segments through the clipper and checks each beat against a predictor or a directed table value.
module tb;
    import lsc_pkg::*;
    import tb_types::*;

    // Run limits.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 600;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_cfg_we = 1'b0;
    t_cfg_idx i_cfg_idx = REG_LEFT;
    t_coord   i_cfg_data = '0;

    lsc_seg_if seg ();
    lsc_res_if res ();

    line_segment_window_clipper_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_seg     (seg.sink),
        .o_res     (res.source)
    );

    always #4 i_clk = ~i_clk;

    // Window as the predictor sees it, mirrored on every register write.
    longint win_l = 100, win_r = 300, win_b = 100, win_t = 300;
    t_clip_beat clip_queue[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    int  sink_stall_pct = 0;

    // Product and division on wide magnitudes; truncation toward zero
    // falls out of dividing magnitudes and applying the sign afterwards.
    function automatic longint scale_div(longint a, longint b, longint c);
        logic [127:0] prod;
        logic [127:0] q;
        logic [63:0]  ua, ub, uc;
        bit neg;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        uc = c < 0 ? -c : c;
        if (uc == 0) return 0;
        prod = 128'(ua) * 128'(ub);
        q = prod / 128'(uc);
        neg = ((a < 0) != (b < 0)) != (c < 0);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic t_code outcode(longint x, longint y);
        t_code c;
        c = '0;
        if (x < win_l) c |= CODE_LEFT;
        else if (x > win_r) c |= CODE_RIGHT;
        if (y < win_b) c |= CODE_BOTTOM;
        else if (y > win_t) c |= CODE_TOP;
        return c;
    endfunction

    function automatic t_clip_beat clip_segment(t_coord sx, t_coord sy, t_coord ex,
                                                t_coord ey);
        longint x1, y1, x2, y2, nx, ny;
        t_code c1, c2, c;
        t_clip_beat r;
        bit ok;
        x1 = sx; y1 = sy; x2 = ex; y2 = ey;
        ok = 1'b0;
        for (int rnd = 0; rnd <= MAX_ROUNDS; rnd++) begin
            c1 = outcode(x1, y1);
            c2 = outcode(x2, y2);
            if ((c1 | c2) == 0) begin
                ok = 1'b1;
                break;
            end
            if ((c1 & c2) != 0 || rnd == MAX_ROUNDS) break;
            c = c1 != 0 ? c1 : c2;
            if (c & CODE_TOP) begin
                nx = x1 + scale_div(x2 - x1, win_t - y1, y2 - y1);
                ny = win_t;
            end else if (c & CODE_BOTTOM) begin
                nx = x1 + scale_div(x2 - x1, win_b - y1, y2 - y1);
                ny = win_b;
            end else if (c & CODE_RIGHT) begin
                ny = y1 + scale_div(y2 - y1, win_r - x1, x2 - x1);
                nx = win_r;
            end else begin
                ny = y1 + scale_div(y2 - y1, win_l - x1, x2 - x1);
                nx = win_l;
            end
            if (c1 != 0) begin
                x1 = nx; y1 = ny;
            end else begin
                x2 = nx; y2 = ny;
            end
        end
        r.accepted = ok;
        r.sx = ok ? t_coord'(x1) : '0;
        r.sy = ok ? t_coord'(y1) : '0;
        r.ex = ok ? t_coord'(x2) : '0;
        r.ey = ok ? t_coord'(y2) : '0;
        return r;
    endfunction

    // Result side: random stalls, and every accepted beat compared with the
    // oldest expected one.
    always @(posedge i_clk) begin
        t_clip_beat got, want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= sink_stall_pct);
            if (res.valid && res.ready) begin
                got = '{res.accepted, res.clip_start_x, res.clip_start_y,
                        res.clip_end_x, res.clip_end_y};
                if (clip_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = clip_queue.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("clip mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no beat accepted on either channel.
    always @(posedge i_clk) begin
        if ((seg.valid && seg.ready) || (res.valid && res.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_window(t_cfg_idx idx, t_coord val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LEFT:   win_l = val;
            REG_RIGHT:  win_r = val;
            REG_BOTTOM: win_b = val;
            REG_TOP:    win_t = val;
        endcase
    endtask

    // Drops valid and waits for the block to drain before the window is touched.
    task automatic wait_idle();
        seg.valid <= 1'b0;
        while (clip_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Sends one segment; the expected beat is queued at the accepting edge so
    // it is always ahead of the result it belongs to. Valid stays high into the
    // next segment unless a gap is taken.
    task automatic send_segment(t_coord sx, t_coord sy, t_coord ex, t_coord ey,
                                int gap_pct, bit typed, t_clip_beat want);
        while ($urandom_range(99) < gap_pct) begin
            seg.valid <= 1'b0;
            @(posedge i_clk);
        end
        seg.valid   <= 1'b1;
        seg.start_x <= sx;
        seg.start_y <= sy;
        seg.end_x   <= ex;
        seg.end_y   <= ey;
        @(posedge i_clk);
        while (!seg.ready) @(posedge i_clk);
        clip_queue.push_back(typed ? want : clip_segment(sx, sy, ex, ey));
    endtask

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(400) - 50);
            default: return t_coord'(win_l + $urandom_range(200) - 100);
        endcase
    endfunction

    t_seg_row rows[$];
    initial begin
        t_seg_row r;
        t_clip_beat none;
        int gap_pct;
        none = '0;
        seg.valid = 1'b0;
        seg.start_x = '0; seg.start_y = '0; seg.end_x = '0; seg.end_y = '0;

        // Directed table under the reset window 100..300.
        rows = '{
            '{150, 150, 250, 250, 1, '{1'b1, 16'sd150, 16'sd150, 16'sd250, 16'sd250}},
            '{100, 100, 300, 300, 1, '{1'b1, 16'sd100, 16'sd100, 16'sd300, 16'sd300}},
            '{0, 0, 50, 50, 1, none},
            '{400, 0, 500, 50, 1, none},
            '{0, 400, 50, 500, 1, none},
            '{-32768, -32768, 32767, 32767, 0, none},
            '{32767, -32768, -32768, 32767, 0, none},
            '{50, 200, 350, 200, 1, '{1'b1, 16'sd100, 16'sd200, 16'sd300, 16'sd200}},
            '{200, 50, 200, 350, 1, '{1'b1, 16'sd200, 16'sd100, 16'sd200, 16'sd300}},
            '{0, 150, 150, 0, 0, none},
            '{-32768, 200, 32767, 201, 0, none},
            '{200, 200, 200, 200, 1, '{1'b1, 16'sd200, 16'sd200, 16'sd200, 16'sd200}},
            '{-1, -1, -1, -1, 1, none},
            '{32767, 32767, 32767, 32767, 1, none},
            '{50, 50, 350, 350, 1, '{1'b1, 16'sd100, 16'sd100, 16'sd300, 16'sd300}},
            '{-7, 103, 299, 401, 0, none},
            '{150, 350, 350, 150, 0, none}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            r = rows[k];
            send_segment(r.sx, r.sy, r.ex, r.ey, 0, r.typed, r.want);
        end

        // Random phases, each under its own window; the extremes of the
        // register range and an inverted window are among them.
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_window(REG_LEFT, -32768); write_window(REG_RIGHT, 32767);
                    write_window(REG_BOTTOM, -32768); write_window(REG_TOP, 32767);
                end
                1: begin
                    write_window(REG_LEFT, 300); write_window(REG_RIGHT, 100);
                    write_window(REG_BOTTOM, 250); write_window(REG_TOP, 50);
                end
                2: begin
                    write_window(REG_LEFT, 32767); write_window(REG_RIGHT, 32767);
                    write_window(REG_BOTTOM, -32768); write_window(REG_TOP, -32768);
                end
                default: begin
                    write_window(REG_LEFT, t_coord'($urandom_range(200) - 100));
                    write_window(REG_RIGHT, t_coord'($urandom_range(200) + 100));
                    write_window(REG_BOTTOM, t_coord'($urandom));
                    write_window(REG_TOP, t_coord'(win_b + $urandom_range(300)));
                end
            endcase
            case (ph % 4)
                0: begin gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin gap_pct = 86; sink_stall_pct = 0;  end
                2: begin gap_pct = 0;  sink_stall_pct = 86; end
                default: begin gap_pct = 13; sink_stall_pct = 13; end
            endcase
            for (int n = 0; n < 175; n++) begin
                int mode;
                mode = $urandom_range(2);
                send_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                             rand_coord(mode), gap_pct, 1'b0, none);
            end
        end

        seg.valid <= 1'b0;
        while (clip_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
